>>> rtl/rlr_pkg.sv
// ----------------------------------------------------------------------------
// rlr_pkg
// Shared widths, register indexes and channel types of the linear ramp block.
// ----------------------------------------------------------------------------
package rlr_pkg;

    localparam int LEVEL_BITS    = 16;
    localparam int TIME_BITS     = 32;
    localparam int DURATION_BITS = 24;

    localparam int PROD_BITS     = LEVEL_BITS + DURATION_BITS;
    localparam int CMP_BITS      = (TIME_BITS > DURATION_BITS) ? TIME_BITS : DURATION_BITS;
    localparam int CFG_DATA_BITS = (DURATION_BITS > LEVEL_BITS) ? DURATION_BITS : LEVEL_BITS;
    localparam int CFG_IDX_BITS  = 2;
    localparam int DIV_CNT_BITS  = $clog2(LEVEL_BITS + 1);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_RISE_TIME     = 2'd0,
        REG_FALL_TIME     = 2'd1,
        REG_INITIAL_LEVEL = 2'd2
    } reg_idx_t;

    typedef enum logic {
        FUNC_TICK     = 1'b0,
        FUNC_RETARGET = 1'b1
    } func_t;

    typedef struct packed {
        logic                  func;
        logic [TIME_BITS-1:0]  now;
        logic [LEVEL_BITS-1:0] target;
    } rlr_in_t;

    typedef struct packed {
        logic [LEVEL_BITS-1:0] level;
        logic                  ramping;
    } rlr_out_t;

    typedef struct packed {
        logic                     start;
        logic [PROD_BITS-1:0]     dividend;
        logic [DURATION_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [LEVEL_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

>>> rtl/rlr_divider.sv
// ----------------------------------------------------------------------------
// rlr_divider
// Restoring divider, one quotient bit per cycle; quotient known to fit
// LEVEL_BITS because the dividend is below divisor times 2**LEVEL_BITS.
// ----------------------------------------------------------------------------
module rlr_divider
    import rlr_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [DURATION_BITS-1:0] rem_reg,  rem_next;
    logic [LEVEL_BITS-1:0]    sh_reg,   sh_next;
    logic [DURATION_BITS-1:0] dvs_reg,  dvs_next;
    logic [DIV_CNT_BITS-1:0]  cnt_reg,  cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [DURATION_BITS:0]   trial;
    logic [DURATION_BITS:0]   diff;

    assign trial = {rem_reg, sh_reg[LEVEL_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        sh_next   = sh_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            rem_next  = req.dividend[PROD_BITS-1:LEVEL_BITS];
            sh_next   = req.dividend[LEVEL_BITS-1:0];
            dvs_next  = req.divisor;
            cnt_next  = DIV_CNT_BITS'(LEVEL_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[DURATION_BITS]) begin
                rem_next = diff[DURATION_BITS-1:0];
                sh_next  = {sh_reg[LEVEL_BITS-2:0], 1'b1};
            end else begin
                rem_next = trial[DURATION_BITS-1:0];
                sh_next  = {sh_reg[LEVEL_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - DIV_CNT_BITS'(1);
            if (cnt_reg == DIV_CNT_BITS'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        sh_reg  <= sh_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = sh_reg;

endmodule

>>> rtl/retargetable_linear_ramp_top.sv
// ----------------------------------------------------------------------------
// retargetable_linear_ramp_top
// Linear level ramp toward a retargetable goal with rise and fall durations.
//
// Input channel s_*: one item per transfer, a tick or a retarget with a time
// stamp. Result channel m_*: exactly one level/ramping result per item.
// Config channel cfg_*: rise_time, fall_time, initial_level; writing
// initial_level reloads all level state and ends any ramp. cfg_ready is
// always high; write only while no item is in flight.
// m_valid is registered. An item that needs no interpolation goes from idle
// straight to the update step; while a ramp is in progress it passes through
// the multiply step, a 16-step serial divide (one quotient bit per cycle)
// and then the update step.
// s_ready is high only while the sequencer is idle, so a new item is not
// taken until the last one is through. A finished result sits in the output
// register, so the next item is taken while it waits; a stalled receiver
// holds the sequencer in its update step once a second result is ready.
// Reset zeroes config, level state and m_valid; sequencer idle, no ramp active.
// ----------------------------------------------------------------------------
module retargetable_linear_ramp_top
    import rlr_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  rlr_in_t                  s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output rlr_out_t                 m_data,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_MUL  = 4'b0010,
        S_DIV  = 4'b0100,
        S_UPD  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [DURATION_BITS-1:0] rise_reg,  rise_next;
    logic [DURATION_BITS-1:0] fall_reg,  fall_next;
    logic [LEVEL_BITS-1:0]    start_reg, start_next;
    logic [LEVEL_BITS-1:0]    goal_reg,  goal_next;
    logic [LEVEL_BITS-1:0]    pres_reg,  pres_next;
    logic [TIME_BITS-1:0]     t0_reg,    t0_next;
    logic [DURATION_BITS-1:0] len_reg,   len_next;

    logic                     func_reg,    func_next;
    logic [TIME_BITS-1:0]     now_reg,     now_next;
    logic [LEVEL_BITS-1:0]    target_reg,  target_next;
    logic                     active_reg,  active_next;
    logic                     snap_reg,    snap_next;
    logic [DURATION_BITS-1:0] elapsed_reg, elapsed_next;
    logic [PROD_BITS-1:0]     prod_reg,    prod_next;

    logic     m_valid_reg, m_valid_next;
    rlr_out_t m_data_reg,  m_data_next;

    logic                  s_fire;
    logic                  cfg_fire;
    logic                  out_free;
    logic [TIME_BITS-1:0]  diff;
    logic [CMP_BITS-1:0]   diff_ext;
    logic [CMP_BITS-1:0]   len_ext;
    logic                  up;
    logic [LEVEL_BITS-1:0] span;
    logic [LEVEL_BITS-1:0] interp;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign out_free  = !m_valid_reg || m_ready;

    assign diff     = s_data.now - t0_reg;
    assign diff_ext = CMP_BITS'(diff);
    assign len_ext  = CMP_BITS'(len_reg);
    assign up       = (goal_reg >= start_reg);
    assign span     = up ? (goal_reg - start_reg) : (start_reg - goal_reg);
    assign interp   = !active_reg ? pres_reg :
                      up ? (start_reg + div_rsp.quotient) : (start_reg - div_rsp.quotient);

    assign div_req.start    = (state_reg == S_MUL);
    assign div_req.dividend = prod_next;
    assign div_req.divisor  = len_reg;

    rlr_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next   = state_reg;
        func_next    = func_reg;
        now_next     = now_reg;
        target_next  = target_reg;
        active_next  = active_reg;
        snap_next    = snap_reg;
        elapsed_next = elapsed_reg;
        prod_next    = prod_reg;
        rise_next    = rise_reg;
        fall_next    = fall_reg;
        start_next   = start_reg;
        goal_next    = goal_reg;
        pres_next    = pres_reg;
        t0_next      = t0_reg;
        len_next     = len_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    func_next    = s_data.func;
                    now_next     = s_data.now;
                    target_next  = s_data.target;
                    active_next  = (len_reg != '0) && (s_data.now > t0_reg);
                    snap_next    = (diff_ext >= len_ext);
                    elapsed_next = (diff_ext >= len_ext) ? len_reg
                                                         : diff[DURATION_BITS-1:0];
                    if ((len_reg != '0) && (s_data.now > t0_reg)) begin
                        state_next = S_MUL;
                    end else begin
                        state_next = S_UPD;
                    end
                end
            end
            S_MUL: begin
                prod_next  = PROD_BITS'(span) * PROD_BITS'(elapsed_reg);
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_rsp.done) begin
                    state_next = S_UPD;
                end
            end
            S_UPD: begin
                if (out_free) begin
                    if (func_reg == FUNC_TICK) begin
                        if (active_reg && snap_reg) begin
                            start_next = goal_reg;
                            pres_next  = goal_reg;
                            t0_next    = now_reg;
                            len_next   = '0;
                        end else begin
                            pres_next = interp;
                        end
                    end else begin
                        goal_next = target_reg;
                        t0_next   = now_reg;
                        if (target_reg > interp) begin
                            len_next = rise_reg;
                        end else if (target_reg < interp) begin
                            len_next = fall_reg;
                        end else begin
                            len_next = '0;
                        end
                        if (len_next == '0) begin
                            start_next = target_reg;
                            pres_next  = target_reg;
                        end else begin
                            start_next = interp;
                            pres_next  = interp;
                        end
                    end
                    m_valid_next        = 1'b1;
                    m_data_next.level   = pres_next;
                    m_data_next.ramping = (len_next != '0);
                    state_next          = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_fire) begin
            unique case (cfg_index)
                REG_RISE_TIME: begin
                    rise_next = cfg_data[DURATION_BITS-1:0];
                end
                REG_FALL_TIME: begin
                    fall_next = cfg_data[DURATION_BITS-1:0];
                end
                REG_INITIAL_LEVEL: begin
                    start_next = cfg_data[LEVEL_BITS-1:0];
                    goal_next  = cfg_data[LEVEL_BITS-1:0];
                    pres_next  = cfg_data[LEVEL_BITS-1:0];
                    t0_next    = '0;
                    len_next   = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            rise_reg    <= '0;
            fall_reg    <= '0;
            start_reg   <= '0;
            goal_reg    <= '0;
            pres_reg    <= '0;
            t0_reg      <= '0;
            len_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            rise_reg    <= rise_next;
            fall_reg    <= fall_next;
            start_reg   <= start_next;
            goal_reg    <= goal_next;
            pres_reg    <= pres_next;
            t0_reg      <= t0_next;
            len_reg     <= len_next;
        end
        func_reg    <= func_next;
        now_reg     <= now_next;
        target_reg  <= target_next;
        active_reg  <= active_next;
        snap_reg    <= snap_next;
        elapsed_reg <= elapsed_next;
        prod_reg    <= prod_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    a_no_ramp_flat: assert property (@(posedge aclk) disable iff (!aresetn)
        (len_reg == '0) |-> (start_reg == pres_reg))
        else $error("level state inconsistent with idle ramp");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_ready)
        else $error("input accepted twice in a row");

    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide step");

    a_result_from_update: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == S_UPD))
        else $error("result raised outside update step");

endmodule
